### sv/kvt_pkg.sv
// Shared types, codes and default sizes for the keyed table.
package kvt_pkg;

    localparam int DepthDefault       = 64;
    localparam int PayloadBitsDefault = 64;
    localparam int KeyBits            = 32;
    localparam int PayloadPortBits    = 64;
    localparam int CountBits          = 7;
    localparam logic [CountBits-1:0] CapacityReset = 7'd64;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_GET    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUP_ADD   = 3'd2,
        STAT_GET_MISS  = 3'd3,
        STAT_DEL_MISS  = 3'd4,
        STAT_UPD_MISS  = 3'd5,
        STAT_KEY_TAKEN = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        kind_t                        kind;
        logic signed [KeyBits-1:0]    key;
        logic signed [KeyBits-1:0]    new_key;
        logic [PayloadPortBits-1:0]   payload;
    } req_t;

    typedef struct packed {
        status_t                      status;
        logic signed [KeyBits-1:0]    found_key;
        logic [PayloadPortBits-1:0]   found_payload;
        logic [CountBits-1:0]         entry_count;
    } rsp_t;

endpackage

### sv/kvt_mem.sv
// Entry store: one write port, one read port with registered read data.
module kvt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/keyed_table_unique_ids.sv
// Keyed table top level: request sequencer, entry store and result register.
// Requests are handled one at a time: each request scans the stored keys through
//   the single read port, and a new one is taken only once its result has been
//   written to the result register.
// Reset: table empty, capacity 64; entry memory is not cleared, since only
//   slots below the entry count are ever read.
module keyed_table_unique_ids #(
    parameter int DEPTH        = kvt_pkg::DepthDefault,
    parameter int PAYLOAD_BITS = kvt_pkg::PayloadBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  kvt_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output kvt_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kvt_pkg::CountBits-1:0] cfg_data
);

    import kvt_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int MEM_W  = KeyBits + PAYLOAD_BITS;

    // Sequencer state
    state_t                  state_reg, state_next;
    req_t                    req_reg, req_next;
    logic [CountBits-1:0]    rd_idx_reg, rd_idx_next;   // next slot to read
    logic                    chk_valid_reg, chk_valid_next;   // read data pending
    logic [CountBits-1:0]    chk_idx_reg, chk_idx_next;  // slot of pending data
    logic                    found_reg, found_next;
    logic                    taken_reg, taken_next;
    logic [CountBits-1:0]    slot_reg, slot_next;
    logic signed [KeyBits-1:0] hit_key_reg, hit_key_next;
    logic [PAYLOAD_BITS-1:0] hit_pl_reg, hit_pl_next;

    // Table and configuration
    logic [CountBits-1:0]    used_reg, used_next;
    logic [CountBits-1:0]    capacity_reg;

    // Result register
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    // Memory port signals
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic [MEM_W-1:0]        mem_wr_data;
    logic                    mem_rd_en;
    logic [MEM_W-1:0]        mem_rd_data;
    logic signed [KeyBits-1:0] rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pl;
    logic                    table_full;

    function automatic logic [AW-1:0] to_addr(input logic [CountBits-1:0] c);
        return AW'(32'(c));
    endfunction

    assign rd_key = mem_rd_data[MEM_W-1 -: KeyBits];
    assign rd_pl  = mem_rd_data[PAYLOAD_BITS-1:0];

    // Capacity saturates at DEPTH; zero capacity rejects every add.
    assign table_full = (32'(used_reg) >= 32'(capacity_reg)) ||
                        (32'(used_reg) >= DEPTH);

    kvt_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MEM_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (to_addr(rd_idx_reg)),
        .rd_data (mem_rd_data)
    );

    // Configuration: the single capacity register takes every write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            used_reg      <= '0;
            capacity_reg  <= CapacityReset;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        found_reg   <= found_next;
        taken_reg   <= taken_next;
        slot_reg    <= slot_next;
        hit_key_reg <= hit_key_next;
        hit_pl_reg  <= hit_pl_next;
        rsp_reg     <= rsp_next;
    end

    // One request at a time. A scan reads slots 0..used-1 in order, one per
    // cycle, and checks each key the cycle after its read. A delete closes the
    // gap during the same pass: once the key is found, every later entry is
    // written back one slot lower. The write always trails the read address,
    // so the same entry is never read and written in one cycle.
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rd_idx_next    = rd_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        taken_next     = taken_reg;
        slot_next      = slot_reg;
        hit_key_next   = hit_key_reg;
        hit_pl_next    = hit_pl_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    taken_next  = 1'b0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the next read
                if (rd_idx_reg < used_reg)
                begin
                    mem_rd_en      = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg;
                    rd_idx_next    = rd_idx_reg + 7'd1;
                end
                // Check the entry read last cycle
                if (chk_valid_reg)
                begin
                    if (req_reg.kind == KIND_DELETE && found_reg)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = to_addr(chk_idx_reg - 7'd1);
                        mem_wr_data = mem_rd_data;
                    end
                    if (rd_key == req_reg.key && !found_reg)
                    begin
                        found_next   = 1'b1;
                        slot_next    = chk_idx_reg;
                        hit_key_next = rd_key;
                        hit_pl_next  = rd_pl;
                    end
                    if (rd_key == req_reg.new_key && rd_key != req_reg.key)
                    begin
                        taken_next = 1'b1;
                    end
                end
                if (rd_idx_reg >= used_reg && !chk_valid_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Hold until the result register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = STAT_OK;
                    rsp_next.found_key     = '0;
                    rsp_next.found_payload = '0;
                    case (req_reg.kind)
                        KIND_ADD:
                        begin
                            if (table_full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else if (found_reg)
                            begin
                                rsp_next.status = STAT_DUP_ADD;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = to_addr(used_reg);
                                mem_wr_data = {req_reg.key,
                                               req_reg.payload[PAYLOAD_BITS-1:0]};
                                used_next   = used_reg + 7'd1;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (!found_reg)
                            begin
                                rsp_next.status = STAT_DEL_MISS;
                            end
                            else
                            begin
                                used_next = used_reg - 7'd1;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            if (taken_reg)
                            begin
                                rsp_next.status = STAT_KEY_TAKEN;
                            end
                            else if (!found_reg)
                            begin
                                rsp_next.status = STAT_UPD_MISS;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = to_addr(slot_reg);
                                mem_wr_data = {req_reg.new_key,
                                               req_reg.payload[PAYLOAD_BITS-1:0]};
                            end
                        end
                        KIND_GET:
                        begin
                            if (!found_reg)
                            begin
                                rsp_next.status = STAT_GET_MISS;
                            end
                            else
                            begin
                                rsp_next.found_key     = hit_key_reg;
                                rsp_next.found_payload = PayloadPortBits'(hit_pl_reg);
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                    rsp_next.entry_count = used_next;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sv/kvt_checker.sv
// Port-level checks for the keyed table, bound to the top level.
module kvt_checker #(
    parameter int DEPTH = kvt_pkg::DepthDefault
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input kvt_pkg::rsp_t rsp
);

    import kvt_pkg::*;

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result dropped or changed while stalled");

    // Take one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in progress");

    // Never report more entries than the table holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.entry_count) <= DEPTH)
        else $error("entry count beyond table depth");

    // Keep found fields zero on a failed request
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STAT_OK |-> rsp.found_key == '0 &&
            rsp.found_payload == '0)
        else $error("found fields set on a failed request");

endmodule

bind keyed_table_unique_ids kvt_checker #(
    .DEPTH (DEPTH)
) u_kvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
